>>> hdl/emt_pkg.sv
`default_nettype none

package emt_pkg;

    localparam int TICK_W = 24;
    localparam int TURN_W = 32;
    localparam int ABS_W  = 48;
    localparam int DIV_W  = 8;
    localparam int OFS_W  = 32;

    // configuration register indexes
    localparam logic [1:0] REG_TICK_DIVIDER    = 2'd0;
    localparam logic [1:0] REG_DRIVER_TICKS    = 2'd1;
    localparam logic [1:0] REG_TICKS_PER_TURN  = 2'd2;
    localparam logic [1:0] REG_ZERO_OFFSET     = 2'd3;

    localparam logic [TICK_W-1:0] RST_TICK_DIVIDER = 24'd1;
    localparam logic [TICK_W-1:0] RST_TICKS        = 24'd4096;

    localparam logic [TURN_W-1:0] TURN_MAX = 32'h7FFF_FFFF;
    localparam logic [TURN_W-1:0] TURN_MIN = 32'h8000_0000;

    localparam logic [ABS_W-1:0] ABS_POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [ABS_W-1:0] ABS_NEG_MIN = 48'h8000_0000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRACK,
        ST_MUL,
        ST_SUM,
        ST_PREP,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

>>> hdl/encoder_multiturn_tracker_unit.sv
`default_nettype none

// channel  | valid    | ready    | payload
// ---------+----------+----------+---------------------------------------------
// input    | i_valid  | o_ready  | i_raw_count
// output   | o_valid  | i_ready  | o_reading_valid, o_turn_total,
//          |          |          | o_position_in_turn, o_absolute_ticks,
//          |          |          | o_absolute_turns_q16
// config   | i_cfg_wr_en (no ready) | i_cfg_index, i_cfg_wdata
//
// one word passes ST_TRACK, ST_MUL, ST_SUM, ST_PREP, ST_DIV and ST_FIN before
// ST_DONE loads the output register; the bit-serial restoring divider in ST_DIV
// makes one quotient bit a cycle over 48 + FRACTION_BITS bits.
// a word that is not yet a valid reading skips the arithmetic.
// o_ready is high only while the sequencer is idle; the output register lets a
// new word enter while the last result still waits on i_ready.
// synchronous active-low reset restores the register defaults and clears tracking.

module encoder_multiturn_tracker_unit #(
    parameter int RAW_BITS      = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [RAW_BITS-1:0]   i_raw_count,

    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic                       o_reading_valid,
    output logic signed [31:0]         o_turn_total,
    output logic [23:0]                o_position_in_turn,
    output logic signed [47:0]         o_absolute_ticks,
    output logic signed [47:0]         o_absolute_turns_q16,

    input  wire logic                  i_cfg_wr_en,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [31:0]           i_cfg_wdata
);

    localparam int DIV_STEPS = emt_pkg::ABS_W + FRACTION_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // configuration
    logic [emt_pkg::DIV_W-1:0]     r_div;
    logic [emt_pkg::TICK_W-1:0]    r_dtpt;
    logic [emt_pkg::TICK_W-1:0]    r_tpt;
    logic signed [emt_pkg::OFS_W-1:0] r_zoff;

    // tracking state
    logic                          r_seen;
    logic [emt_pkg::TICK_W-1:0]    r_pos;
    logic signed [emt_pkg::TURN_W-1:0] r_wrap;

    // datapath
    logic [emt_pkg::TICK_W-1:0]    r_scaled;
    logic signed [56:0]            r_prod;
    logic signed [emt_pkg::ABS_W-1:0] r_abs;
    logic                          r_neg;
    logic [emt_pkg::ABS_W-1:0]     r_dvd;
    logic [emt_pkg::TICK_W-1:0]    r_rem;
    logic [emt_pkg::ABS_W-1:0]     r_quo;
    logic                          r_ovf;
    logic [CNT_W-1:0]              r_cnt;
    logic signed [emt_pkg::ABS_W-1:0] r_q16;

    // output register
    logic                          r_out_valid;
    logic                          r_out_rv;
    logic signed [31:0]            r_out_turn;
    logic [23:0]                   r_out_pos;
    logic signed [47:0]            r_out_abs;
    logic signed [47:0]            r_out_q16;

    emt_pkg::t_state r_state;
    emt_pkg::t_state n_state;

    logic w_accept;
    logic w_load_out;
    logic w_in_ready;

    logic [31:0]                   w_scale_prod;
    logic [24:0]                   w_diff;
    logic [emt_pkg::TICK_W-1:0]    w_step_mag;
    logic                          w_wrap_hit;
    logic                          w_new_seen;
    logic signed [24:0]            w_dtpt_s;
    logic signed [57:0]            w_sum;
    logic [24:0]                   w_rem_sh;
    logic                          w_ge;
    logic [24:0]                   w_rem_nx;
    logic [emt_pkg::ABS_W-1:0]     w_limit;
    logic [emt_pkg::ABS_W-1:0]     w_res;

    assign w_accept     = i_valid && w_in_ready;
    assign w_scale_prod = 32'(i_raw_count) * 32'(r_div);

    assign w_diff     = {1'b0, r_scaled} - {1'b0, r_pos};
    assign w_step_mag = w_diff[24] ? 24'(25'd0 - w_diff) : w_diff[23:0];
    assign w_wrap_hit = w_step_mag > (r_dtpt >> 1);
    assign w_new_seen = r_seen || (r_scaled != '0);

    assign w_dtpt_s = $signed({1'b0, r_dtpt});
    assign w_sum    = {r_prod[56], r_prod}
                    + $signed({34'd0, r_pos})
                    - {{26{r_zoff[31]}}, r_zoff};

    // one restoring divide step
    assign w_rem_sh = {r_rem, r_dvd[emt_pkg::ABS_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_tpt};
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_tpt}) : w_rem_sh;

    assign w_limit = r_neg ? emt_pkg::ABS_NEG_MIN : emt_pkg::ABS_POS_MAX;
    assign w_res   = (r_ovf || (r_quo > w_limit)) ? w_limit : r_quo;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            emt_pkg::ST_IDLE:  if (i_valid) n_state = emt_pkg::ST_TRACK;
            emt_pkg::ST_TRACK: n_state = w_new_seen ? emt_pkg::ST_MUL : emt_pkg::ST_DONE;
            emt_pkg::ST_MUL:   n_state = emt_pkg::ST_SUM;
            emt_pkg::ST_SUM:   n_state = emt_pkg::ST_PREP;
            emt_pkg::ST_PREP:  n_state = emt_pkg::ST_DIV;
            emt_pkg::ST_DIV:   if (r_cnt == '0) n_state = emt_pkg::ST_FIN;
            emt_pkg::ST_FIN:   n_state = emt_pkg::ST_DONE;
            emt_pkg::ST_DONE:  if (!r_out_valid || i_ready) n_state = emt_pkg::ST_IDLE;
            default:           n_state = emt_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_in_ready = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            emt_pkg::ST_IDLE: w_in_ready = 1'b1;
            emt_pkg::ST_DONE: w_load_out = !r_out_valid || i_ready;
            default: begin
                w_in_ready = 1'b0;
                w_load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= emt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration and tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div  <= emt_pkg::DIV_W'(emt_pkg::RST_TICK_DIVIDER);
            r_dtpt <= emt_pkg::RST_TICKS;
            r_tpt  <= emt_pkg::RST_TICKS;
            r_zoff <= '0;
            r_seen <= 1'b0;
            r_pos  <= '0;
            r_wrap <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    emt_pkg::REG_TICK_DIVIDER: r_div  <= i_cfg_wdata[7:0];
                    emt_pkg::REG_DRIVER_TICKS: r_dtpt <= i_cfg_wdata[23:0];
                    emt_pkg::REG_TICKS_PER_TURN: begin
                        // a changed value restarts tracking
                        if (i_cfg_wdata[23:0] != r_tpt) begin
                            r_tpt  <= i_cfg_wdata[23:0];
                            r_seen <= 1'b0;
                            r_pos  <= '0;
                            r_wrap <= '0;
                        end
                    end
                    emt_pkg::REG_ZERO_OFFSET: r_zoff <= $signed(i_cfg_wdata);
                    default: r_div <= r_div;
                endcase
            end else if (r_state == emt_pkg::ST_TRACK) begin
                if (!r_seen) begin
                    if (r_scaled != '0) begin
                        r_seen <= 1'b1;
                        r_pos  <= r_scaled;
                    end
                end else begin
                    r_pos <= r_scaled;
                    if (w_wrap_hit) begin
                        // backward jump means the count rolled over forward
                        if (w_diff[24]) begin
                            if (r_wrap != $signed(emt_pkg::TURN_MAX)) r_wrap <= r_wrap + 32'sd1;
                        end else begin
                            if (r_wrap != $signed(emt_pkg::TURN_MIN)) r_wrap <= r_wrap - 32'sd1;
                        end
                    end
                end
            end
        end
    end

    // arithmetic datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_scaled <= w_scale_prod[23:0];
        end
        unique case (r_state)
            emt_pkg::ST_MUL: begin
                r_prod <= r_wrap * w_dtpt_s;
            end
            emt_pkg::ST_SUM: begin
                if (w_sum[57:47] != {11{w_sum[57]}}) begin
                    r_abs <= w_sum[57] ? $signed(emt_pkg::ABS_NEG_MIN)
                                       : $signed(emt_pkg::ABS_POS_MAX);
                end else begin
                    r_abs <= w_sum[47:0];
                end
            end
            emt_pkg::ST_PREP: begin
                r_neg <= r_abs[47];
                r_dvd <= r_abs[47] ? (48'd0 - r_abs) : r_abs;
                r_rem <= '0;
                r_quo <= '0;
                r_ovf <= 1'b0;
                r_cnt <= CNT_W'(DIV_STEPS - 1);
            end
            emt_pkg::ST_DIV: begin
                r_dvd <= {r_dvd[46:0], 1'b0};
                r_rem <= w_rem_nx[23:0];
                r_quo <= {r_quo[46:0], w_ge};
                r_ovf <= r_ovf || r_quo[47];
                r_cnt <= r_cnt - 1'b1;
            end
            emt_pkg::ST_FIN: begin
                if (r_tpt == '0) begin
                    r_q16 <= '0;
                end else begin
                    r_q16 <= r_neg ? $signed(48'd0 - w_res) : $signed(w_res);
                end
            end
            default: begin
                r_q16 <= r_q16;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_rv <= r_seen;
            if (r_seen) begin
                r_out_turn <= r_wrap;
                r_out_pos  <= r_pos;
                r_out_abs  <= r_abs;
                r_out_q16  <= r_q16;
            end else begin
                r_out_turn <= '0;
                r_out_pos  <= '0;
                r_out_abs  <= '0;
                r_out_q16  <= '0;
            end
        end
    end

    assign o_ready              = w_in_ready;
    assign o_valid              = r_out_valid;
    assign o_reading_valid      = r_out_rv;
    assign o_turn_total         = r_out_turn;
    assign o_position_in_turn   = r_out_pos;
    assign o_absolute_ticks     = r_out_abs;
    assign o_absolute_turns_q16 = r_out_q16;

endmodule

`default_nettype wire
